### src/ett_pkg.sv
// shared types and constants of the expiring ticket table
package ett_pkg;

   localparam logic [1:0] CMD_HOLD = 2'd0;
   localparam logic [1:0] CMD_TAKE = 2'd1;
   localparam logic [1:0] CMD_DROP = 2'd2;

   localparam logic [31:0] TICKET_FIRST   = 32'd1;
   localparam logic [15:0] LIFETIME_RESET = 16'd60;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIFETIME = 3'd0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now;
      logic [31:0] ticket_in;
      logic [31:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [31:0] ticket_out;
      logic        found;
      logic [31:0] payload_out;
      logic        evicted;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now;
      logic [31:0] ticket;
      logic [31:0] expiry;
      logic [31:0] payload;
   } job_type;

endpackage

### src/ett_ram.sv
// generic single write port ram with registered read
module ett_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ett_fifo.sv
// small register queue used between the front, the back and the result port
module ett_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/ett_front.sv
// front end: accepts commands, computes the saturated expiry and queues the job
module ett_front (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      lifetime,
   input  logic             push,
   input  ett_pkg::req_type req_data,
   output logic             full,
   input  logic             job_pop,
   output logic             job_empty,
   output ett_pkg::job_type job_data
);

   logic [32:0]      expiry_sum;
   ett_pkg::job_type job_new;

   assign expiry_sum = {1'b0, req_data.now} + {17'b0, lifetime};

   always_comb begin
      job_new.cmd     = req_data.cmd;
      job_new.now     = req_data.now;
      job_new.ticket  = req_data.ticket_in;
      job_new.expiry  = expiry_sum[32] ? '1 : expiry_sum[31:0];
      job_new.payload = req_data.payload_in;
   end

   ett_fifo #(
      .WIDTH ($bits(ett_pkg::job_type)),
      .DEPTH (2)
   ) u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (job_new),
      .rd_en   (job_pop),
      .rd_data (job_data),
      .full    (full),
      .empty   (job_empty)
   );

endmodule

### src/ett_back.sv
// back end: scans the entry table once per job, then applies hold, take or drop
module ett_back #(
   parameter int TABLE_DEPTH   = 16,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  ett_pkg::job_type job_data,
   output logic             job_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output ett_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SCAN    = 2'd1;
   localparam logic [1:0] S_FINISH  = 2'd2;
   localparam logic [1:0] S_PAYLOAD = 2'd3;

   logic [1:0]             state_ff, state_in;
   ett_pkg::job_type       job_ff, job_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   chk_ff, chk_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       live_cnt_ff, live_cnt_in;
   logic                   best_any_ff, best_any_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [31:0]            best_exp_ff, best_exp_in;
   logic [31:0]            best_tkt_ff, best_tkt_in;
   logic                   match_ff, match_in;
   logic [IDX_W-1:0]       match_idx_ff, match_idx_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [31:0]            next_ticket_ff, next_ticket_in;

   logic [IDX_W-1:0]         rd_addr;
   logic                     ram_wr;
   logic [IDX_W-1:0]         target;
   logic [31:0]              tkt_rd;
   logic [31:0]              exp_rd;
   logic [PAYLOAD_WIDTH-1:0] pay_rd;
   logic [31:0]              key;
   logic [31:0]              tkt_inc;
   logic                     ent_valid;
   logic                     ent_live;
   logic                     ent_better;
   logic                     table_full;
   logic                     issue;

   assign key        = (job_ff.cmd == ett_pkg::CMD_HOLD) ? next_ticket_ff : job_ff.ticket;
   assign tkt_inc    = next_ticket_ff + 32'd1;
   assign ent_valid  = valid_ff[chk_idx_ff];
   assign ent_live   = ent_valid && (exp_rd > job_ff.now);
   assign ent_better = !best_any_ff || (exp_rd < best_exp_ff) ||
                       ((exp_rd == best_exp_ff) && (tkt_rd < best_tkt_ff));
   assign table_full = (live_cnt_ff == CNT_DEPTH);
   assign issue      = (rd_idx_ff < CNT_DEPTH);
   assign target     = match_ff ? match_idx_ff : (table_full ? best_idx_ff : free_idx_ff);

   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      rd_idx_in      = rd_idx_ff;
      chk_in         = 1'b0;
      chk_idx_in     = chk_idx_ff;
      valid_in       = valid_ff;
      live_cnt_in    = live_cnt_ff;
      best_any_in    = best_any_ff;
      best_idx_in    = best_idx_ff;
      best_exp_in    = best_exp_ff;
      best_tkt_in    = best_tkt_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      next_ticket_in = next_ticket_ff;
      job_pop        = 1'b0;
      rsp_push       = 1'b0;
      rsp_data       = '0;
      ram_wr         = 1'b0;
      rd_addr        = rd_idx_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (!job_empty && !rsp_full) begin
               job_pop     = 1'b1;
               job_in      = job_data;
               rd_idx_in   = '0;
               live_cnt_in = '0;
               best_any_in = 1'b0;
               match_in    = 1'b0;
               free_in     = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               chk_in     = 1'b1;
               chk_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
            if (chk_ff) begin
               if (ent_valid && !ent_live) begin
                  valid_in[chk_idx_ff] = 1'b0;
               end
               if (!ent_live && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (ent_live) begin
                  live_cnt_in = live_cnt_ff + 1'b1;
                  if (ent_better) begin
                     best_any_in = 1'b1;
                     best_idx_in = chk_idx_ff;
                     best_exp_in = exp_rd;
                     best_tkt_in = tkt_rd;
                  end
                  if (tkt_rd == key && !match_ff) begin
                     match_in     = 1'b1;
                     match_idx_in = chk_idx_ff;
                  end
               end
            end
         end
         S_FINISH: begin
            rd_addr  = match_idx_ff;
            state_in = S_IDLE;
            case (job_ff.cmd)
               ett_pkg::CMD_HOLD: begin
                  if (table_full) begin
                     valid_in[best_idx_ff] = 1'b0;
                  end
                  valid_in[target]    = 1'b1;
                  ram_wr              = 1'b1;
                  next_ticket_in      = (tkt_inc == '0) ? ett_pkg::TICKET_FIRST : tkt_inc;
                  rsp_push            = 1'b1;
                  rsp_data.ticket_out = next_ticket_ff;
                  rsp_data.found      = 1'b1;
                  rsp_data.evicted    = table_full;
               end
               ett_pkg::CMD_TAKE: begin
                  if (match_ff) begin
                     valid_in[match_idx_ff] = 1'b0;
                     state_in               = S_PAYLOAD;
                  end else begin
                     rsp_push = 1'b1;
                  end
               end
               ett_pkg::CMD_DROP: begin
                  if (match_ff) begin
                     valid_in[match_idx_ff] = 1'b0;
                  end
                  rsp_push       = 1'b1;
                  rsp_data.found = match_ff;
               end
               default: begin
                  rsp_push = 1'b1;
               end
            endcase
         end
         S_PAYLOAD: begin
            rsp_push             = 1'b1;
            rsp_data.found       = 1'b1;
            rsp_data.payload_out = 32'(pay_rd);
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         chk_ff         <= 1'b0;
         valid_ff       <= '0;
         next_ticket_ff <= ett_pkg::TICKET_FIRST;
      end else begin
         state_ff       <= state_in;
         chk_ff         <= chk_in;
         valid_ff       <= valid_in;
         next_ticket_ff <= next_ticket_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      live_cnt_ff  <= live_cnt_in;
      best_any_ff  <= best_any_in;
      best_idx_ff  <= best_idx_in;
      best_exp_ff  <= best_exp_in;
      best_tkt_ff  <= best_tkt_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
   end

   ett_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_ticket_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (target),
      .wr_data (next_ticket_ff),
      .rd_addr (rd_addr),
      .rd_data (tkt_rd)
   );

   ett_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_expiry_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (target),
      .wr_data (job_ff.expiry),
      .rd_addr (rd_addr),
      .rd_data (exp_rd)
   );

   ett_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (target),
      .wr_data (PAYLOAD_WIDTH'(job_ff.payload)),
      .rd_addr (rd_addr),
      .rd_data (pay_rd)
   );

endmodule

### src/expiring_ticket_table.sv
// top level of the expiring ticket table
// commands are handled one at a time: the back end takes no new job until it has scanned
//   every entry through the single read port of the entry memories and pushed its result
// reset: synchronous; clears all valid bits, sets lifetime to 60 and the next ticket to 1
module expiring_ticket_table #(
   parameter int TABLE_DEPTH   = 16,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  ett_pkg::req_type                 req_data,
   output logic                             empty,
   input  logic                             pop,
   output ett_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ett_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   logic [15:0]      lifetime_ff, lifetime_in;
   logic             job_pop;
   logic             job_empty;
   ett_pkg::job_type job_data;
   logic             res_full;
   logic             res_push;
   ett_pkg::rsp_type res_data;

   assign pready = 1'b1;
   assign prdata = (paddr == ett_pkg::CSR_LIFETIME) ? {16'b0, lifetime_ff} : '0;

   always_comb begin
      lifetime_in = lifetime_ff;
      if (psel && penable && pwrite && (paddr == ett_pkg::CSR_LIFETIME)) begin
         lifetime_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= ett_pkg::LIFETIME_RESET;
      end else begin
         lifetime_ff <= lifetime_in;
      end
   end

   ett_front u_front (
      .clock     (clock),
      .reset     (reset),
      .lifetime  (lifetime_ff),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .job_pop   (job_pop),
      .job_empty (job_empty),
      .job_data  (job_data)
   );

   ett_back #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_data  (res_data)
   );

   ett_fifo #(
      .WIDTH ($bits(ett_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_data),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .full    (res_full),
      .empty   (empty)
   );

endmodule

### src/ett_checker.sv
// port level checker for the expiring ticket table, bound to the top level
module ett_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input ett_pkg::rsp_type rsp_data,
   input logic             pready
);

   // queues are empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // an eviction only comes with a hold, which always carries a nonzero ticket
   a_evict_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.evicted) |-> (rsp_data.found && (rsp_data.ticket_out != '0)))
      else $error("eviction reported without a hold result");

   // a hold result never carries a payload
   a_hold_no_payload: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.ticket_out != '0)) |-> (rsp_data.found && (rsp_data.payload_out == '0)))
      else $error("hold result carries a payload");

   // a waiting result stays put until it is popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed while waiting");

   // the register port never stalls
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind expiring_ticket_table ett_checker u_checker (.*);
